// ===== hdl/isort_pkg.sv =====
// isort_pkg: shared width constant, the cell control struct and the sequencer state type for the insertion sorter.
// No dependencies. Imported by isort_cell, insertion_sorter and tb.
`timescale 1ns / 1ps

package isort_pkg;

  // Width of one sorted word
  localparam int unsigned WORD_W = 32;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the new word, shift greater words up one cell
    logic drain;   // shift every word down one cell toward the output
  } isort_ctrl_t;

  // Top level sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } isort_state_t;

endpackage

// ===== hdl/isort_cell.sv =====
// isort_cell: one slot of the insertion chain; holds a word and trades with its neighbors.
// Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_cell
  import isort_pkg::*;
(
  input  logic                     clk,
  input  isort_ctrl_t              ctrl,
  input  logic                     occupied,   // slot holds a word of the current run
  input  logic signed [WORD_W-1:0] new_word,   // word being inserted
  input  logic                     left_gt,    // lower neighbor moves up
  input  logic signed [WORD_W-1:0] left_word,
  input  logic signed [WORD_W-1:0] right_word,
  output logic                     gt,         // this slot gives way to the new word
  output logic signed [WORD_W-1:0] word
);

  // Empty slots count as greater, so the new word lands in the first free one
  assign gt = !occupied || (word > new_word);

  // Insert: take the lower neighbor if it also moves, else the new word. Drain: shift down.
  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      word <= left_gt ? left_word : new_word;
    end else if (ctrl.drain) begin
      word <= right_word;
    end
  end

endmodule

// ===== hdl/insertion_sorter.sv =====
// insertion_sorter: stable ascending sort of a run of signed words in a chain of cells.
// Accepts one word per cycle while loading; after the word marked last, busy rises and the
// run streams out from cell 0 one word per cycle, first result in the cycle after that word.
// Busy stays high until all N stored words of a run are out; the next run may start right after.
// Words beyond MAX_ITEMS are dropped and flagged on every result of the run.
// Synchronous reset empties the chain and returns to loading; results cannot be stalled.
`timescale 1ns / 1ps

module insertion_sorter
  import isort_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [WORD_W-1:0] value,
  input  logic                     last,
  output logic                     valid,
  output logic signed [WORD_W-1:0] value_res,
  output logic                     last_res,
  output logic                     overflow
);

  localparam int unsigned FILL_W = $clog2(MAX_ITEMS + 1);

  isort_state_t      state;
  logic [FILL_W-1:0] fill;
  logic              dropped;
  logic              accept;
  logic              full;
  isort_ctrl_t       ctrl;

  logic                     gt   [MAX_ITEMS];
  logic signed [WORD_W-1:0] word [MAX_ITEMS];

  assign busy   = (state == ST_DRAIN);
  assign accept = start && !busy;
  assign full   = (fill == FILL_W'(MAX_ITEMS));

  assign ctrl.insert = accept && !full;
  assign ctrl.drain  = busy;

  // Chain of cells, cell 0 holds the smallest word
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                     l_gt;
    logic signed [WORD_W-1:0] l_word;
    logic signed [WORD_W-1:0] r_word;

    if (i == 0) begin : g_first
      assign l_gt   = 1'b0;
      assign l_word = '0;
    end else begin : g_mid_l
      assign l_gt   = gt[i-1];
      assign l_word = word[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign r_word = '0;
    end else begin : g_mid_r
      assign r_word = word[i+1];
    end

    isort_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (FILL_W'(i) < fill),
      .new_word  (value),
      .left_gt   (l_gt),
      .left_word (l_word),
      .right_word(r_word),
      .gt        (gt[i]),
      .word      (word[i])
    );
  end

  // Sequencer: fill count, drop flag, load/drain state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      fill    <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              fill <= fill + FILL_W'(1);
            end
            if (last) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          fill <= fill - FILL_W'(1);
          if (fill == FILL_W'(1)) begin
            state   <= ST_LOAD;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Result word comes straight off cell 0
  assign valid     = busy;
  assign value_res = word[0];
  assign last_res  = busy && (fill == FILL_W'(1));
  assign overflow  = dropped;

  // Draining never starts or runs with an empty chain
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (fill != '0))
    else $error("drain with empty chain");

  // An accepted last word always starts the drain
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> busy)
    else $error("last word did not start drain");

  // Final result ends the drain and clears the drop flag
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    last_res |=> (!busy && (fill == '0) && !dropped))
    else $error("drain did not end after final result");

  // Fill count stays within capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for insertion_sorter; drives runs of signed words, predicts sorted output.
// Depends on isort_pkg (WORD_W) and the insertion_sorter RTL, which itself needs isort_cell.
`timescale 1ns / 1ps

module tb;
  import isort_pkg::*;

  localparam int unsigned SORT_DEPTH   = 64;
  localparam int unsigned RANDOM_WORDS = 270;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_GAP      = 12;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  // One expected output word
  typedef struct {
    word_t word;
    bit    is_last;
    bit    ovf;
  } sorted_word_t;

  // Keeps a shadow of the sorted store and the queue of words still to come out
  class sort_scoreboard;
    word_t        run_words[$];
    bit           dropped;
    sorted_word_t pending[$];
    int unsigned  fails;

    // Accepted input word: stable insert, or drop when the store is full
    function void note_word(word_t v, bit is_last);
      int           pos;
      sorted_word_t r;
      if (run_words.size() < SORT_DEPTH) begin
        pos = run_words.size();
        // only strictly greater entries move up; equal ones stay ahead
        while (pos > 0 && run_words[pos-1] > v) pos--;
        run_words.insert(pos, v);
      end else begin
        dropped = 1'b1;
      end
      if (is_last) begin
        foreach (run_words[k]) begin
          r.word    = run_words[k];
          r.is_last = (k == run_words.size() - 1);
          r.ovf     = dropped;
          pending.push_back(r);
        end
        run_words.delete();
        dropped = 1'b0;
      end
    endfunction

    // Output word seen on the strobe: compare against the oldest expectation
    function void check_result(word_t v, bit is_last, bit ovf);
      sorted_word_t exp_word;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output word, value_res %0d last_res %0b overflow %0b",
                 $time, v, is_last, ovf);
        fails++;
        return;
      end
      exp_word = pending.pop_front();
      if (v !== exp_word.word) begin
        $display("%0t: value_res mismatch, expected %0d, got %0d", $time, exp_word.word, v);
        fails++;
      end
      if (is_last !== exp_word.is_last) begin
        $display("%0t: last_res mismatch, expected %0b, got %0b",
                 $time, exp_word.is_last, is_last);
        fails++;
      end
      if (ovf !== exp_word.ovf) begin
        $display("%0t: overflow mismatch, expected %0b, got %0b", $time, exp_word.ovf, ovf);
        fails++;
      end
    endfunction
  endclass

  logic  clk   = 1'b0;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  word_t value = '0;
  logic  last  = 1'b0;
  logic  busy;
  logic  valid;
  word_t value_res;
  logic  last_res;
  logic  overflow;

  sort_scoreboard board;
  word_t          run_buf[$];
  int unsigned    words_sent;
  int unsigned    cycle_count;

  insertion_sorter #(.MAX_ITEMS(SORT_DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .value    (value),
    .last     (last),
    .valid    (valid),
    .value_res(value_res),
    .last_res (last_res),
    .overflow (overflow)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Output monitor: a word is taken on the edge that ends its strobe cycle
  always @(posedge clk) begin
    if (!rst && valid) begin
      board.check_result(value_res, last_res, overflow);
    end
  end

  // Present one word, hold it until accepted, then maybe idle
  task automatic send_word(input word_t v, input bit is_last, input bit no_gaps);
    int unsigned gap;
    start <= 1'b1;
    value <= v;
    last  <= is_last;
    do @(posedge clk); while (busy);
    board.note_word(v, is_last);
    words_sent++;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send run_buf as one run, final word marked last
  task automatic play_run(input bit no_gaps);
    foreach (run_buf[k]) send_word(run_buf[k], k == run_buf.size() - 1, no_gaps);
    run_buf.delete();
  endtask

  // Mix of extremes, a narrow band for duplicates, and full-range words
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3, 4: return word_t'(int'($urandom_range(0, 8)) - 4);
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned run_len;
    int unsigned run_idx;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-word runs at the extremes
    run_buf.push_back(WORD_MIN);
    play_run(1'b0);
    run_buf.push_back(WORD_MAX);
    play_run(1'b1);
    // extremes and zero crossing, scrambled
    run_buf = '{WORD_MAX, WORD_MIN, -1, 0, 1};
    play_run(1'b0);
    // duplicates
    run_buf = '{5, 5, -5, 5, WORD_MIN, WORD_MIN};
    play_run(1'b1);
    // already ascending, then descending
    run_buf = '{1, 2, 3, 4};
    play_run(1'b0);
    run_buf = '{4, 3, 2, 1};
    play_run(1'b0);

    // Random runs: mostly short, a few that fill or overflow the store
    run_idx = 0;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (run_idx == 1)
        run_len = SORT_DEPTH;
      else if (run_idx == 3)
        run_len = SORT_DEPTH + 2;
      else if ($urandom_range(0, 11) == 0)
        run_len = $urandom_range(SORT_DEPTH - 4, SORT_DEPTH + 8);
      else
        run_len = $urandom_range(1, 10);
      repeat (run_len) run_buf.push_back(rand_word());
      play_run($urandom_range(0, 3) == 0);
      run_idx++;
    end

    // Drain everything still owed, then a short settle
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (board.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
